>>> rtl/core/frcb_pkg.sv
package frcb_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam logic [7:0] CMD_READ    = 8'h06;
  localparam logic [7:0] CMD_OPT_MF  = 8'h40;
  localparam logic [7:0] SIZE_CODE   = 8'd2;
  localparam logic [7:0] GAP_LEN     = 8'd27;
  localparam logic [7:0] DATA_LEN    = 8'hff;

  // reset values of the configuration registers
  localparam logic [5:0]  SPT_RESET   = 6'd18;
  localparam logic [1:0]  HEADS_RESET = 2'd2;
  localparam logic [12:0] TOTAL_RESET = 13'd2880;
  localparam logic [1:0]  DRIVE_RESET = 2'd0;

  // radix-4 divider: 13-bit dividend padded to 14 bits, two bits per step
  localparam int unsigned DIV_STEPS = 7;

  // floor(x / 3) == (x * DIV3_RECIP) >> 16 for every 13-bit x
  localparam logic [14:0] DIV3_RECIP = 15'd21846;

  typedef enum logic [1:0] {
    REG_SPT   = 2'd0,
    REG_HEADS = 2'd1,
    REG_TOTAL = 2'd2,
    REG_DRIVE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    POS_OPCODE = 4'd0,
    POS_SELECT = 4'd1,
    POS_CYL    = 4'd2,
    POS_HEAD   = 4'd3,
    POS_SECTOR = 4'd4,
    POS_SIZE   = 4'd5,
    POS_SPT    = 4'd6,
    POS_GAP    = 4'd7,
    POS_DTL    = 4'd8
  } cmd_pos_t;

  // effective configuration (zero sector and head counts already mapped to one)
  typedef struct packed {
    logic [5:0]  spt;
    logic [1:0]  heads;
    logic [12:0] total;
    logic [1:0]  drive;
  } frcb_cfg_t;

  // one classified request, handed from front to back
  typedef struct packed {
    logic        oor;
    logic [1:0]  head;
    logic [7:0]  cyl;
    logic [5:0]  sector;
    logic [5:0]  spt;
    logic [14:0] xfer;
  } frcb_desc_t;

endpackage

>>> rtl/core/frcb_divider.sv
module frcb_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [12:0] dividend,
  input  logic [5:0]  divisor,
  output logic        done,
  output logic [12:0] quotient,
  output logic [5:0]  remainder
);
  import frcb_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [2:0]  cnt_r;
  logic [13:0] quo_r;
  logic [5:0]  rem_r;
  logic [5:0]  div_r;
  logic [6:0]  s1;
  logic [6:0]  s2;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [6:0] div_step(input logic [5:0] r, input logic b,
                                          input logic [5:0] d);
    logic [6:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, 6'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[5:0]};
    end
  endfunction

  always_comb begin
    s1 = div_step(rem_r, quo_r[13], div_r);
    s2 = div_step(s1[5:0], quo_r[12], div_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= 3'(cnt_r + 3'd1);
      if (cnt_r == 3'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {1'b0, dividend};
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      quo_r <= {quo_r[11:0], s1[6], s2[6]};
      rem_r <= s2[5:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r[12:0];
  assign remainder = rem_r;

endmodule

>>> rtl/core/frcb_front.sv
module frcb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  frcb_pkg::frcb_cfg_t   cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [12:0]           in_block_address,
  input  logic [15:0]           in_request_bytes,
  output logic                  push_valid,
  input  logic                  push_ready,
  output frcb_pkg::frcb_desc_t  push_desc
);
  import frcb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_t;

  state_t      state_r;
  logic        oor_r;
  logic [15:0] req_r;
  logic [12:0] track_r;
  logic [12:0] cyl_r;
  logic [5:0]  sector_r;
  logic [14:0] xfer_r;

  logic        accept;
  logic        in_oor;
  logic        div_start;
  logic        div_done;
  logic [12:0] div_quo;
  logic [5:0]  div_rem;
  logic [28:0] prod3;
  logic [12:0] cyl_nxt;
  logic [5:0]  left;
  logic [14:0] cap;
  logic [14:0] xfer_nxt;
  logic [14:0] cyl_heads;
  logic [12:0] head_diff;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_PUSH) && push_ready);
  assign accept    = in_valid && in_ready;
  assign in_oor    = in_block_address >= cfg.total;
  assign div_start = accept && !in_oor;

  frcb_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_block_address),
    .divisor   (cfg.spt),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // cylinder = track / heads, heads is one to three
  always_comb begin
    prod3 = 29'(div_quo) * 29'(DIV3_RECIP);
    case (cfg.heads)
      2'd1:    cyl_nxt = div_quo;
      2'd2:    cyl_nxt = div_quo >> 1;
      default: cyl_nxt = prod3[28:16];
    endcase
  end

  // sectors left on the track = spt - remainder
  always_comb begin
    left     = 6'(cfg.spt - div_rem);
    cap      = 15'(left) << SECTOR_SHIFT;
    xfer_nxt = (req_r < {1'b0, cap}) ? req_r[14:0] : cap;
  end

  always_comb begin
    cyl_heads = 15'(cyl_r) * 15'(cfg.heads);
    head_diff = 13'(track_r - cyl_heads[12:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      oor_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE, S_PUSH: begin
          if (accept) begin
            oor_r   <= in_oor;
            state_r <= in_oor ? S_PUSH : S_DIV;
          end else if (state_r == S_PUSH && push_ready) begin
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_PUSH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_request_bytes;
    end
    if (state_r == S_DIV && div_done) begin
      track_r  <= div_quo;
      cyl_r    <= cyl_nxt;
      sector_r <= 6'(div_rem + 6'd1);
      xfer_r   <= xfer_nxt;
    end
  end

  assign push_valid = (state_r == S_PUSH);

  always_comb begin
    push_desc = '0;
    push_desc.oor = oor_r;
    if (!oor_r) begin
      push_desc.head   = head_diff[1:0];
      push_desc.cyl    = cyl_r[7:0];
      push_desc.sector = sector_r;
      push_desc.spt    = cfg.spt;
      push_desc.xfer   = xfer_r;
    end
  end

endmodule

>>> rtl/core/frcb_queue.sv
module frcb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  frcb_pkg::frcb_desc_t  wr_desc,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output frcb_pkg::frcb_desc_t  rd_desc
);
  import frcb_pkg::*;

  frcb_desc_t  slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_desc  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= 2'(count_r + 2'd1);
      end else if (pop && !push) begin
        count_r <= 2'(count_r - 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

>>> rtl/core/frcb_back.sv
module frcb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            drive,
  input  logic                  rd_valid,
  output logic                  rd_ready,
  input  frcb_pkg::frcb_desc_t  rd_desc,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_command_byte,
  output logic                  out_last_byte,
  output logic [14:0]           out_transfer_bytes,
  output logic                  out_out_of_range
);
  import frcb_pkg::*;

  cmd_pos_t    pos_r;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [14:0] xfer_r;
  logic        oor_r;

  logic        load;
  logic        last_nxt;
  logic [7:0]  byte_nxt;

  assign load     = rd_valid && (!out_valid_r || out_ready);
  assign last_nxt = rd_desc.oor || (pos_r == POS_DTL);
  assign rd_ready = load && last_nxt;

  always_comb begin
    case (pos_r)
      POS_OPCODE: byte_nxt = CMD_READ | CMD_OPT_MF;
      POS_SELECT: byte_nxt = {4'd0, rd_desc.head, drive};
      POS_CYL:    byte_nxt = rd_desc.cyl;
      POS_HEAD:   byte_nxt = {6'd0, rd_desc.head};
      POS_SECTOR: byte_nxt = {2'd0, rd_desc.sector};
      POS_SIZE:   byte_nxt = SIZE_CODE;
      POS_SPT:    byte_nxt = {2'd0, rd_desc.spt};
      POS_GAP:    byte_nxt = GAP_LEN;
      POS_DTL:    byte_nxt = DATA_LEN;
      default:    byte_nxt = '0;
    endcase
    if (rd_desc.oor) begin
      byte_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= POS_OPCODE;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= last_nxt ? POS_OPCODE : cmd_pos_t'(pos_r + 4'd1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      xfer_r <= rd_desc.xfer;
      oor_r  <= rd_desc.oor;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command_byte   = byte_r;
  assign out_last_byte      = last_r;
  assign out_transfer_bytes = xfer_r;
  assign out_out_of_range   = oor_r;

endmodule

>>> rtl/core/floppy_read_command_builder_unit.sv
// path from input transaction to first command byte: the 7-step radix-4 divider,
// a register stage that splits cylinder and head, the queue, the output register
// output: nine command bytes per request; the front takes no new request while
// its divider is busy; an out-of-range address gives one result
// reset: synchronous active-low rst_n clears control and loads the register defaults
module floppy_read_command_builder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [12:0] in_block_address,
  input  logic [15:0] in_request_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_command_byte,
  output logic        out_last_byte,
  output logic [14:0] out_transfer_bytes,
  output logic        out_out_of_range
);
  import frcb_pkg::*;

  logic [5:0]  spt_r;
  logic [1:0]  heads_r;
  logic [12:0] total_r;
  logic [1:0]  drive_r;
  frcb_cfg_t   cfg;

  logic        push_valid;
  logic        push_ready;
  frcb_desc_t  push_desc;
  logic        rd_valid;
  logic        rd_ready;
  frcb_desc_t  rd_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r   <= SPT_RESET;
      heads_r <= HEADS_RESET;
      total_r <= TOTAL_RESET;
      drive_r <= DRIVE_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SPT:   spt_r   <= cfg_data[5:0];
        REG_HEADS: heads_r <= cfg_data[1:0];
        REG_TOTAL: total_r <= cfg_data;
        REG_DRIVE: drive_r <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  // zero sector and head counts behave as one
  always_comb begin
    cfg.spt   = (spt_r == '0) ? 6'd1 : spt_r;
    cfg.heads = (heads_r == '0) ? 2'd1 : heads_r;
    cfg.total = total_r;
    cfg.drive = drive_r;
  end

  frcb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_block_address (in_block_address),
    .in_request_bytes (in_request_bytes),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_desc        (push_desc)
  );

  frcb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_desc  (push_desc),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_desc  (rd_desc)
  );

  frcb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .drive              (cfg.drive),
    .rd_valid           (rd_valid),
    .rd_ready           (rd_ready),
    .rd_desc            (rd_desc),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command_byte   (out_command_byte),
    .out_last_byte      (out_last_byte),
    .out_transfer_bytes (out_transfer_bytes),
    .out_out_of_range   (out_out_of_range)
  );

endmodule
